@@ design/lmbs_pkg.sv @@
// Shared types and codes for the LED matrix bit-plane scanner.
// Used by the front, the command queue wiring and the back of the scanner.
// No dependencies.
package lmbs_pkg;

  // Input opcodes as they arrive on in_tuser.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // Fixed widths set by the item fields.
  localparam int COLOR_W    = 24;
  localparam int PLANE_W    = 3;
  localparam int ROW_ADDR_W = 3;

  // Command kinds passed from the front to the back.
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_kind_t;

  // Control part of one queued command.
  typedef struct packed {
    cmd_kind_t kind;
    logic      bottom;
  } cmd_ctl_t;

  // Status reported by the back to the front.
  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

@@ design/lmbs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds one half of the frame store. No dependencies.
module lmbs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

@@ design/lmbs_front.sv @@
// Front of the scanner: accepts input items, absorbs items during a clear,
// checks pixel ranges and turns items into commands. Depends on lmbs_pkg.
module lmbs_front #(
  parameter int COLUMNS   = 32,
  parameter int SCAN_ROWS = 8,
  parameter int ADDR_W    = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [1:0]            opcode,
  input  logic [4:0]            pixel_x,
  input  logic [3:0]            pixel_y,
  input  logic [lmbs_pkg::COLOR_W-1:0] color,
  input  lmbs_pkg::back_stat_t  stat,
  input  logic                  q_full,
  output logic                  push,
  output lmbs_pkg::cmd_ctl_t    push_ctl,
  output logic [ADDR_W-1:0]     push_addr,
  output logic [lmbs_pkg::COLOR_W-1:0] push_data
);

  localparam int DEPTH = COLUMNS * SCAN_ROWS;

  logic              busy_r, busy_nxt;
  logic [ADDR_W-1:0] left_r, left_nxt;
  logic              accept;
  logic [8:0]        x_ext;
  logic [6:0]        y_ext;
  logic [6:0]        row_sel;
  logic              in_range;
  logic              is_bottom;

  assign in_tready = !stat.init_busy && !q_full;
  assign accept    = in_tvalid && in_tready;

  // Pixel range check and store address.
  assign x_ext     = 9'(pixel_x);
  assign y_ext     = 7'(pixel_y);
  assign in_range  = (x_ext < 9'(COLUMNS)) && (y_ext < 7'(2 * SCAN_ROWS));
  assign is_bottom = (y_ext >= 7'(SCAN_ROWS));
  assign row_sel   = is_bottom ? (y_ext - 7'(SCAN_ROWS)) : y_ext;
  assign push_addr = ADDR_W'(row_sel) * ADDR_W'(COLUMNS) + ADDR_W'(pixel_x);
  assign push_data = color;

  // Classify the accepted item.
  always_comb begin
    busy_nxt        = busy_r;
    left_nxt        = left_r;
    push            = 1'b0;
    push_ctl.kind   = lmbs_pkg::CMD_TICK;
    push_ctl.bottom = is_bottom;
    if (accept) begin
      if (busy_r) begin
        // Items during a clear are absorbed.
        left_nxt = left_r - ADDR_W'(1);
        if (left_r == ADDR_W'(1)) begin
          busy_nxt = 1'b0;
        end
      end else begin
        case (opcode)
          lmbs_pkg::OP_WRITE: begin
            push          = in_range;
            push_ctl.kind = lmbs_pkg::CMD_WRITE;
          end
          lmbs_pkg::OP_CLEAR: begin
            push          = 1'b1;
            push_ctl.kind = lmbs_pkg::CMD_CLEAR;
            busy_nxt      = (DEPTH > 1);
            left_nxt      = ADDR_W'(DEPTH - 1);
          end
          lmbs_pkg::OP_TICK: begin
            push          = 1'b1;
            push_ctl.kind = lmbs_pkg::CMD_TICK;
          end
          default: begin
            push = 1'b0;
          end
        endcase
      end
    end
  end

  // Clear absorb state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      left_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

@@ design/lmbs_cmdq.sv @@
// Two-entry command queue between the front and the back of the scanner.
// No dependencies.
module lmbs_cmdq #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;

  assign empty   = (count_r == 2'd0);
  assign full    = (count_r == 2'd2);
  assign head    = slot_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and fill count update.
  always_comb begin
    wptr_nxt  = do_push ? !wptr_r : wptr_r;
    rptr_nxt  = do_pop ? !rptr_r : rptr_r;
    count_nxt = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

endmodule

@@ design/lmbs_back.sv @@
// Back of the scanner: runs queued commands, sweeps the stores to zero,
// walks the scan order and drives the result register. Depends on lmbs_pkg.
module lmbs_back #(
  parameter int COLUMNS   = 32,
  parameter int SCAN_ROWS = 8,
  parameter int PLANES    = 8,
  parameter int ADDR_W    = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Command queue head.
  input  logic                  q_empty,
  input  lmbs_pkg::cmd_ctl_t    q_ctl,
  input  logic [ADDR_W-1:0]     q_addr,
  input  logic [lmbs_pkg::COLOR_W-1:0] q_data,
  output logic                  q_pop,
  output lmbs_pkg::back_stat_t  stat,
  // Store ports.
  output logic                  top_we,
  output logic                  bot_we,
  output logic [ADDR_W-1:0]     waddr,
  output logic [lmbs_pkg::COLOR_W-1:0] wdata,
  output logic                  re,
  output logic [ADDR_W-1:0]     raddr,
  input  logic [lmbs_pkg::COLOR_W-1:0] top_rdata,
  input  logic [lmbs_pkg::COLOR_W-1:0] bot_rdata,
  // Result channel.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // red_top, green_top, blue_top, red_bottom,
                                            // green_bottom, blue_bottom, row_address[2:0],
                                            // plane_index[2:0], zero fill
  output logic [1:0]            out_tuser,  // shift_strobe, latch_strobe
  output logic                  out_tlast   // frame_end
);

  localparam int DEPTH = COLUMNS * SCAN_ROWS;
  localparam int COL_W = $clog2(COLUMNS + 1);
  localparam int ROW_W = $clog2(SCAN_ROWS);
  localparam int PW    = lmbs_pkg::PLANE_W;

  typedef enum logic [1:0] {
    ST_SWEEP = 2'b01,
    ST_RUN   = 2'b10
  } back_state_t;

  back_state_t       state_r, state_nxt;
  logic              init_r, init_nxt;
  logic [ADDR_W-1:0] sweep_r, sweep_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [PW-1:0]     plane_r, plane_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_shift_r, s1_latch_r, s1_last_r;
  logic [2:0]        s1_row_r;
  logic [PW-1:0]     s1_plane_r;
  logic              s1_load;
  logic              s1_adv;
  logic              s1_shift_nxt, s1_last_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [5:0]        out_color_r;
  logic              out_shift_r, out_latch_r, out_last_r;
  logic [2:0]        out_row_r;
  logic [PW-1:0]     out_plane_r;

  logic              tick_room;
  logic [7:0]        row_wide;
  logic [4:0]        bit_r, bit_g, bit_b;
  logic [5:0]        color_bits;

  assign stat.init_busy = init_r;
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign tick_room = !s1_valid_r || s1_adv;
  assign row_wide  = 8'(row_r);
  assign raddr     = ADDR_W'(row_r) * ADDR_W'(COLUMNS) + ADDR_W'(col_r);

  // Command execution and scan order.
  always_comb begin
    state_nxt    = state_r;
    init_nxt     = init_r;
    sweep_nxt    = sweep_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    plane_nxt    = plane_r;
    q_pop        = 1'b0;
    top_we       = 1'b0;
    bot_we       = 1'b0;
    waddr        = q_addr;
    wdata        = q_data;
    re           = 1'b0;
    s1_load      = 1'b0;
    s1_shift_nxt = 1'b0;
    s1_last_nxt  = 1'b0;
    case (state_r)
      ST_SWEEP: begin
        // Zero one entry of both halves per cycle.
        top_we = 1'b1;
        bot_we = 1'b1;
        waddr  = sweep_r;
        wdata  = '0;
        if (sweep_r == ADDR_W'(DEPTH - 1)) begin
          sweep_nxt = '0;
          init_nxt  = 1'b0;
          state_nxt = ST_RUN;
        end else begin
          sweep_nxt = sweep_r + ADDR_W'(1);
        end
      end
      ST_RUN: begin
        if (!q_empty) begin
          case (q_ctl.kind)
            lmbs_pkg::CMD_WRITE: begin
              q_pop  = 1'b1;
              top_we = !q_ctl.bottom;
              bot_we = q_ctl.bottom;
            end
            lmbs_pkg::CMD_CLEAR: begin
              q_pop     = 1'b1;
              sweep_nxt = '0;
              state_nxt = ST_SWEEP;
            end
            lmbs_pkg::CMD_TICK: begin
              if (tick_room) begin
                q_pop   = 1'b1;
                s1_load = 1'b1;
                if (col_r < COL_W'(COLUMNS)) begin
                  // Column shift: fetch the pixel of both halves.
                  re           = 1'b1;
                  s1_shift_nxt = 1'b1;
                  col_nxt      = col_r + COL_W'(1);
                end else begin
                  // Latch step: advance plane, then row.
                  s1_last_nxt = (row_r == ROW_W'(SCAN_ROWS - 1)) &&
                                (plane_r == PW'(PLANES - 1));
                  col_nxt     = '0;
                  if (plane_r == PW'(PLANES - 1)) begin
                    plane_nxt = '0;
                    if (row_r == ROW_W'(SCAN_ROWS - 1)) begin
                      row_nxt = '0;
                    end else begin
                      row_nxt = row_r + ROW_W'(1);
                    end
                  end else begin
                    plane_nxt = plane_r + PW'(1);
                  end
                end
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_SWEEP;
        sweep_nxt = '0;
      end
    endcase
  end

  // Stage and result valid flags.
  always_comb begin
    s1_valid_nxt = s1_load ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Plane bit selection from the registered read data.
  assign bit_r = 5'(s1_plane_r);
  assign bit_g = 5'(s1_plane_r) + 5'd8;
  assign bit_b = 5'(s1_plane_r) + 5'd16;
  assign color_bits = s1_shift_r ?
      {bot_rdata[bit_b], bot_rdata[bit_g], bot_rdata[bit_r],
       top_rdata[bit_b], top_rdata[bit_g], top_rdata[bit_r]} : 6'd0;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      init_r      <= 1'b1;
      sweep_r     <= '0;
      col_r       <= '0;
      row_r       <= '0;
      plane_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      sweep_r     <= sweep_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      plane_r     <= plane_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers of the read stage and the result.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_shift_r <= s1_shift_nxt;
      s1_latch_r <= !s1_shift_nxt;
      s1_last_r  <= s1_last_nxt;
      s1_row_r   <= row_wide[2:0];
      s1_plane_r <= plane_r;
    end
    if (s1_adv) begin
      out_color_r <= color_bits;
      out_shift_r <= s1_shift_r;
      out_latch_r <= s1_latch_r;
      out_last_r  <= s1_last_r;
      out_row_r   <= s1_row_r;
      out_plane_r <= s1_plane_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_plane_r, out_row_r, out_color_r};
  assign out_tuser  = {out_latch_r, out_shift_r};
  assign out_tlast  = out_last_r;

endmodule

@@ design/led_matrix_bitplane_scanner.sv @@
// Top level of the LED matrix bit-plane scanner: front, command queue,
// back and the two half-panel frame stores. Depends on lmbs_pkg and all lmbs_ modules.
//
//  Channel  | Signals                          | Carries
//  ---------+----------------------------------+--------------------------------------
//  input    | in_tvalid/in_tready/in_tdata/    | pixel writes, clear, scan ticks
//           | in_tuser                         |
//  result   | out_tvalid/out_tready/out_tdata/ | one result per scan tick
//           | out_tuser/out_tlast              |
//
// Writes and scan ticks are taken one per cycle while in_tready is high; a
// tick's result passes through the command queue, the store read and the
// result register. A clear command absorbs the next COLUMNS*SCAN_ROWS-1
// items, while the back zeroes the stores one entry per cycle. After reset
// the same zeroing pass runs over all COLUMNS*SCAN_ROWS entries (256 by
// default) with in_tready low.
// A stalled result backs up through the read stage and the two-entry queue.
module led_matrix_bitplane_scanner #(
  parameter int COLUMNS   = 32,
  parameter int SCAN_ROWS = 8,
  parameter int PLANES    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // pixel_x[4:0], pixel_y[3:0], red[7:0], green[7:0],
                                  // blue[7:0], zero fill
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // red_top, green_top, blue_top, red_bottom, green_bottom,
                                  // blue_bottom, row_address[2:0], plane_index[2:0], zero fill
  output logic [1:0]  out_tuser,  // shift_strobe, latch_strobe
  output logic        out_tlast   // frame_end
);

  localparam int DEPTH  = COLUMNS * SCAN_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CW     = lmbs_pkg::COLOR_W;
  localparam int CTL_W  = $bits(lmbs_pkg::cmd_ctl_t);
  localparam int QW     = CTL_W + ADDR_W + CW;

  lmbs_pkg::back_stat_t stat;
  lmbs_pkg::cmd_ctl_t   push_ctl;
  lmbs_pkg::cmd_ctl_t   q_ctl;
  logic                 push;
  logic [ADDR_W-1:0]    push_addr;
  logic [CW-1:0]        push_data;
  logic [QW-1:0]        q_head;
  logic                 q_empty, q_full, q_pop;
  logic [ADDR_W-1:0]    q_addr;
  logic [CW-1:0]        q_data;
  logic                 top_we, bot_we, re;
  logic [ADDR_W-1:0]    waddr, raddr;
  logic [CW-1:0]        wdata, top_rdata, bot_rdata;

  // Front: accept and classify.
  lmbs_front #(
    .COLUMNS   (COLUMNS),
    .SCAN_ROWS (SCAN_ROWS),
    .ADDR_W    (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .opcode    (in_tuser),
    .pixel_x   (in_tdata[4:0]),
    .pixel_y   (in_tdata[8:5]),
    .color     (in_tdata[32:9]),
    .stat      (stat),
    .q_full    (q_full),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_addr (push_addr),
    .push_data (push_data)
  );

  // Command queue between front and back.
  lmbs_cmdq #(
    .WIDTH (QW)
  ) u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_ctl, push_addr, push_data}),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign q_ctl  = q_head[QW-1 -: CTL_W];
  assign q_addr = q_head[CW +: ADDR_W];
  assign q_data = q_head[CW-1:0];

  // Back: execute commands and scan.
  lmbs_back #(
    .COLUMNS   (COLUMNS),
    .SCAN_ROWS (SCAN_ROWS),
    .PLANES    (PLANES),
    .ADDR_W    (ADDR_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_ctl      (q_ctl),
    .q_addr     (q_addr),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .stat       (stat),
    .top_we     (top_we),
    .bot_we     (bot_we),
    .waddr      (waddr),
    .wdata      (wdata),
    .re         (re),
    .raddr      (raddr),
    .top_rdata  (top_rdata),
    .bot_rdata  (bot_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Top-half frame store.
  lmbs_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_top_ram (
    .clk     (clk),
    .we      (top_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr   (raddr),
    .rdata_r (top_rdata)
  );

  // Bottom-half frame store.
  lmbs_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_bot_ram (
    .clk     (clk),
    .we      (bot_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr   (raddr),
    .rdata_r (bot_rdata)
  );

endmodule

@@ test/tb_top.sv @@
// Testbench for led_matrix_bitplane_scanner: pixel writes, frame clears and scan ticks are
// streamed in with random bursts and gaps, and each scan result is checked against a built-in
// model of the bit-plane stores and scan counters. Depends on lmbs_pkg and the scanner RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS     = 32;
  localparam int SCAN_ROWS   = 8;
  localparam int PLANES      = 8;
  localparam int STORE_DEPTH = COLUMNS * SCAN_ROWS;
  localparam int TAIL_CYCLES = 20;
  localparam int PRINT_LIMIT = 40;

  // Opcode value the block does not decode.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One input item as it travels on in_tdata/in_tuser.
  typedef struct {
    logic [1:0] opcode;
    logic [4:0] px;
    logic [3:0] py;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_cmd_t;

  // One scan result, one member per output field.
  typedef struct {
    logic       red_top;
    logic       green_top;
    logic       blue_top;
    logic       red_bottom;
    logic       green_bottom;
    logic       blue_bottom;
    logic       shift;
    logic       latch;
    logic [2:0] row;
    logic [2:0] plane;
    logic       frame_end;
  } scan_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // pixel_x[4:0], pixel_y[3:0], red, green, blue, zero fill
  logic [1:0]  in_tuser = '0;   // opcode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // red_top .. blue_bottom, row_address[2:0], plane_index[2:0]
  logic [1:0]  out_tuser;       // shift_strobe, latch_strobe
  logic        out_tlast;       // frame_end

  led_matrix_bitplane_scanner #(
    .COLUMNS  (COLUMNS),
    .SCAN_ROWS(SCAN_ROWS),
    .PLANES   (PLANES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // Model state: both half-panel stores, the scan position and the clear countdown.
  logic [23:0]  top_pixels [STORE_DEPTH];
  logic [23:0]  bottom_pixels [STORE_DEPTH];
  int           scan_col;
  int           scan_plane;
  int           scan_row;
  int           clear_left;

  pixel_cmd_t   cmd_queue [$];
  scan_result_t scan_expect [$];
  int           mismatch_count;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [2:0] got,
                             input logic [2:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Advance the model by one accepted item, queueing a result for a scan tick.
  task automatic scan_model_step(input pixel_cmd_t c);
    int           idx;
    logic [23:0]  t;
    logic [23:0]  b;
    scan_result_t res;
    if (clear_left > 0) begin
      // Items that arrive during a clear are swallowed.
      clear_left--;
    end else begin
      case (c.opcode)
        lmbs_pkg::OP_WRITE: begin
          if (c.px < COLUMNS && c.py < 2 * SCAN_ROWS) begin
            if (c.py < SCAN_ROWS)
              top_pixels[c.py * COLUMNS + c.px] = {c.blue, c.green, c.red};
            else
              bottom_pixels[(c.py - SCAN_ROWS) * COLUMNS + c.px] = {c.blue, c.green, c.red};
          end
        end
        lmbs_pkg::OP_CLEAR: begin
          for (int i = 0; i < STORE_DEPTH; i++) begin
            top_pixels[i] = '0;
            bottom_pixels[i] = '0;
          end
          clear_left = STORE_DEPTH - 1;
        end
        lmbs_pkg::OP_TICK: begin
          res = '{default: 1'b0, row: 3'(scan_row), plane: 3'(scan_plane)};
          if (scan_col < COLUMNS) begin
            idx = scan_row * COLUMNS + scan_col;
            t = top_pixels[idx];
            b = bottom_pixels[idx];
            res.red_top      = t[scan_plane];
            res.green_top    = t[scan_plane + 8];
            res.blue_top     = t[scan_plane + 16];
            res.red_bottom   = b[scan_plane];
            res.green_bottom = b[scan_plane + 8];
            res.blue_bottom  = b[scan_plane + 16];
            res.shift        = 1'b1;
            scan_col++;
          end else begin
            // Latch step: ends the plane-row and moves to the next plane or row.
            res.latch     = 1'b1;
            res.frame_end = (scan_row == SCAN_ROWS - 1) && (scan_plane == PLANES - 1);
            scan_col = 0;
            if (scan_plane == PLANES - 1) begin
              scan_plane = 0;
              scan_row = (scan_row == SCAN_ROWS - 1) ? 0 : scan_row + 1;
            end else begin
              scan_plane++;
            end
          end
          scan_expect.push_back(res);
        end
        default: ;
      endcase
    end
  endtask

  function automatic pixel_cmd_t make_cmd(input logic [1:0] op, input int x, input int y,
                                          input int r, input int g, input int b);
    pixel_cmd_t c;
    c.opcode = op;
    c.px     = 5'(x);
    c.py     = 4'(y);
    c.red    = 8'(r);
    c.green  = 8'(g);
    c.blue   = 8'(b);
    return c;
  endfunction

  // Random item with the given opcode; colors lean toward the extremes now and then.
  function automatic pixel_cmd_t random_cmd(input logic [1:0] op);
    int shade;
    shade = $urandom_range(0, 7);
    if (shade == 0)
      return make_cmd(op, $urandom_range(0, 31), $urandom_range(0, 15), 0, 0, 0);
    else if (shade == 1)
      return make_cmd(op, $urandom_range(0, 31), $urandom_range(0, 15), 255, 255, 255);
    return make_cmd(op, $urandom_range(0, 31), $urandom_range(0, 15),
                    $urandom, $urandom, $urandom);
  endfunction

  // A clear, the items it swallows, and a few ticks that read the zeroed stores.
  task automatic queue_clear();
    cmd_queue.push_back(random_cmd(lmbs_pkg::OP_CLEAR));
    repeat (STORE_DEPTH - 1) cmd_queue.push_back(random_cmd(2'($urandom_range(0, 3))));
    repeat ($urandom_range(1, 6)) cmd_queue.push_back(random_cmd(lmbs_pkg::OP_TICK));
  endtask

  // Random part: runs of writes and runs of ticks, with stray opcodes and clears.
  // At least one clear is queued by the time a third of the target is counted, if max_clears allows.
  task automatic queue_random_traffic(input int target, input int max_clears);
    int counted;
    int clears;
    int pick;
    int n;
    counted = 0;
    clears = 0;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      if (clears == 0 && counted >= target / 3) pick = 99;
      if (pick < 40) begin
        n = $urandom_range(1, 8);
        repeat (n) cmd_queue.push_back(random_cmd(lmbs_pkg::OP_WRITE));
        counted += n;
      end else if (pick < 94) begin
        n = $urandom_range(1, 40);
        repeat (n) cmd_queue.push_back(random_cmd(lmbs_pkg::OP_TICK));
        counted += n;
      end else if (pick < 98 || clears >= max_clears) begin
        cmd_queue.push_back(random_cmd(OP_UNUSED));
      end else begin
        queue_clear();
        clears++;
        counted += STORE_DEPTH;
      end
    end
  endtask

  // Hold off until every queued item is taken and every result has come back.
  task automatic wait_drained();
    while (cmd_queue.size() != 0 || in_tvalid) @(negedge clk);
    while (scan_expect.size() != 0) @(negedge clk);
  endtask

  // Sender: bursts of transfers separated by random gaps.
  pixel_cmd_t cur_cmd;
  int         burst_left = 1;
  int         gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) scan_model_step(cur_cmd);
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (cmd_queue.size() != 0) begin
          cur_cmd = cmd_queue.pop_front();
          in_tdata <= {7'd0, cur_cmd.blue, cur_cmd.green, cur_cmd.red, cur_cmd.py, cur_cmd.px};
          in_tuser <= cur_cmd.opcode;
          in_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: out_tready follows a rotating pattern that changes every so often.
  logic [15:0] ready_pattern = 16'hFFFF;
  int          pattern_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pattern = 16'hFFFF;
          1: ready_pattern = 16'($urandom);
          2: ready_pattern = 16'h0F0F;
          default: ready_pattern = 16'h8001;
        endcase
        pattern_left = $urandom_range(16, 96);
      end
      pattern_left--;
      out_tready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end
  end

  // Result checker: each transfer against the oldest expected scan result.
  always @(posedge clk) begin : result_check
    scan_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (scan_expect.size() == 0) begin
        report_mismatch("scan result with none expected");
      end else begin
        want = scan_expect.pop_front();
        check_field("red_top", out_tdata[0], want.red_top);
        check_field("green_top", out_tdata[1], want.green_top);
        check_field("blue_top", out_tdata[2], want.blue_top);
        check_field("red_bottom", out_tdata[3], want.red_bottom);
        check_field("green_bottom", out_tdata[4], want.green_bottom);
        check_field("blue_bottom", out_tdata[5], want.blue_bottom);
        check_field("row_address", out_tdata[8:6], want.row);
        check_field("plane_index", out_tdata[11:9], want.plane);
        check_field("shift_strobe", out_tuser[0], want.shift);
        check_field("latch_strobe", out_tuser[1], want.latch);
        check_field("frame_end", out_tlast, want.frame_end);
      end
    end
  end

  // Main sequence.
  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      top_pixels[i] = '0;
      bottom_pixels[i] = '0;
    end
    scan_col = 0;
    scan_plane = 0;
    scan_row = 0;
    clear_left = 0;
    mismatch_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: corner pixels in both halves, the unused opcode, then ticks over row 0 columns.
    cmd_queue.push_back(make_cmd(lmbs_pkg::OP_WRITE, 0, 0, 8'hFF, 8'hFF, 8'hFF));
    cmd_queue.push_back(make_cmd(lmbs_pkg::OP_WRITE, 1, 0, 8'h55, 8'hAA, 8'h0F));
    cmd_queue.push_back(make_cmd(lmbs_pkg::OP_WRITE, 0, 8, 8'h80, 8'h01, 8'hFF));
    cmd_queue.push_back(make_cmd(lmbs_pkg::OP_WRITE, 1, 8, 8'h00, 8'hFF, 8'h00));
    cmd_queue.push_back(make_cmd(lmbs_pkg::OP_WRITE, 31, 15, 8'hFF, 8'hFF, 8'hFF));
    cmd_queue.push_back(make_cmd(lmbs_pkg::OP_WRITE, 31, 7, 8'hA5, 8'h5A, 8'hC3));
    cmd_queue.push_back(make_cmd(OP_UNUSED, 31, 15, 8'hFF, 8'hFF, 8'hFF));
    cmd_queue.push_back(make_cmd(lmbs_pkg::OP_TICK, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(lmbs_pkg::OP_TICK, 31, 15, 8'hFF, 8'hFF, 8'hFF));
    cmd_queue.push_back(make_cmd(lmbs_pkg::OP_WRITE, 2, 0, 8'h01, 8'h00, 8'h01));
    cmd_queue.push_back(make_cmd(lmbs_pkg::OP_WRITE, 2, 8, 8'h00, 8'h01, 8'h00));
    cmd_queue.push_back(make_cmd(lmbs_pkg::OP_TICK, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(lmbs_pkg::OP_TICK, 0, 0, 0, 0, 0));
    wait_drained();

    queue_random_traffic(600, 1);
    wait_drained();

    queue_random_traffic(620, 1);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
design/lmbs_pkg.sv
design/lmbs_ram.sv
design/lmbs_front.sv
design/lmbs_cmdq.sv
design/lmbs_back.sv
design/led_matrix_bitplane_scanner.sv
test/tb_top.sv
